/* rtl/peh_pkg.sv */
// Shared types and constants for the pixel energy hit histogram.
// No dependencies.
package peh_pkg;

   localparam int IDX_W = 10;
   localparam int DIV_W = 34;

   localparam logic [1:0] FN_HIT   = 2'd0;
   localparam logic [1:0] FN_READ  = 2'd1;
   localparam logic [1:0] FN_CLEAR = 2'd2;

   localparam logic [1:0] MODE_PARALLEL = 2'd1;

   localparam logic [2:0] ST_COUNTED = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_COLLIM  = 3'd2;
   localparam logic [2:0] ST_GRID    = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;
   localparam logic [2:0] ST_READOUT = 3'd5;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_COSTOL = 3'd1;
   localparam logic [2:0] REG_XORG   = 3'd2;
   localparam logic [2:0] REG_ZORG   = 3'd3;
   localparam logic [2:0] REG_PITCHX = 3'd4;
   localparam logic [2:0] REG_PITCHZ = 3'd5;
   localparam logic [2:0] REG_EMIN   = 3'd6;
   localparam logic [2:0] REG_ESPAN  = 3'd7;

   typedef enum logic [1:0] {
      OP_REJECT = 2'd0,
      OP_HIT    = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [15:0]        energy;
      logic signed [15:0] dir_y;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_z;
      logic [4:0]         sel_col;
      logic [4:0]         sel_row;
      logic [5:0]         sel_bin;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  col;
      logic [4:0]  row;
      logic [5:0]  bin;
      logic [31:0] count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         collimation_mode;
      logic signed [15:0] cos_tolerance;
      logic signed [23:0] x_origin;
      logic signed [23:0] z_origin;
      logic [22:0]        pitch_x;
      logic [22:0]        pitch_z;
      logic [15:0]        energy_min;
      logic [15:0]        energy_span;
   } cfg_type;

   typedef struct packed {
      op_type           op;
      logic             sel_ok;
      logic [2:0]       status;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] bin;
   } entry_type;

endpackage

/* rtl/pixel_energy_hit_histogram.sv */
// Histogram of photon hits over column, row and energy bin.
// Start/busy command channel in, one result word out with a strobe.
// Registers sit behind an APB-style port at byte address 4*index.
// A word is taken at a clock edge with start high and busy low. Hits
// (func 0) are classified, and a hit that passes every cut is indexed by
// three shared-step restoring dividers; read (1 or 3) and clear (2)
// address one counter directly. The front end checks the word, runs the
// dividers for a counted hit and then pushes it to the queue; busy stays
// high meanwhile. A two-entry queue feeds the back end, whose counter
// store takes each word through read, modify-write and result, so the
// back end is never the limit. Each word yields one result, strobed for
// one cycle; the receiver cannot stall and must take it.
// Synchronous reset sets the registers to defaults and starts a clearing
// sweep over all COLS*ROWS*BINS counters (65536 by default) with busy
// high; register writes are taken throughout.
module pixel_energy_hit_histogram #(
   parameter int COLS = 32,
   parameter int ROWS = 32,
   parameter int BINS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  peh_pkg::req_type req_data,
   output logic             rsp_strobe,
   output peh_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import peh_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      front_busy, clearing, push, full, pop, empty;
   entry_type push_data, pop_data;
   logic [2:0] reg_idx;

   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_MODE:   cfg_in.collimation_mode = pwdata[1:0];
            REG_COSTOL: cfg_in.cos_tolerance    = pwdata[15:0];
            REG_XORG:   cfg_in.x_origin         = pwdata[23:0];
            REG_ZORG:   cfg_in.z_origin         = pwdata[23:0];
            REG_PITCHX: cfg_in.pitch_x          = pwdata[22:0];
            REG_PITCHZ: cfg_in.pitch_z          = pwdata[22:0];
            REG_EMIN:   cfg_in.energy_min       = pwdata[15:0];
            REG_ESPAN:  cfg_in.energy_span      = pwdata[15:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODE:   prdata = 32'(cfg_ff.collimation_mode);
         REG_COSTOL: prdata = 32'(cfg_ff.cos_tolerance);
         REG_XORG:   prdata = 32'(cfg_ff.x_origin);
         REG_ZORG:   prdata = 32'(cfg_ff.z_origin);
         REG_PITCHX: prdata = 32'(cfg_ff.pitch_x);
         REG_PITCHZ: prdata = 32'(cfg_ff.pitch_z);
         REG_EMIN:   prdata = 32'(cfg_ff.energy_min);
         REG_ESPAN:  prdata = 32'(cfg_ff.energy_span);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.collimation_mode <= MODE_PARALLEL;
         cfg_ff.cos_tolerance    <= 16'sd32767;
         cfg_ff.x_origin         <= '0;
         cfg_ff.z_origin         <= '0;
         cfg_ff.pitch_x          <= 23'd1;
         cfg_ff.pitch_z          <= 23'd1;
         cfg_ff.energy_min       <= '0;
         cfg_ff.energy_span      <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign busy   = front_busy || clearing;

   peh_front #(.COLS(COLS), .ROWS(ROWS), .BINS(BINS)) u_front (
      .clock(clock), .reset(reset), .start(start && !clearing), .req_data(req_data),
      .cfg(cfg_ff), .front_busy(front_busy), .push(push), .push_data(push_data),
      .full(full)
   );

   peh_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .full(full),
      .pop(pop), .pop_data(pop_data), .empty(empty)
   );

   peh_back #(.COLS(COLS), .ROWS(ROWS), .BINS(BINS)) u_back (
      .clock(clock), .reset(reset), .empty(empty), .pop_data(pop_data), .pop(pop),
      .clearing(clearing), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

endmodule

/* rtl/peh_front.sv */
// Front end: takes one word, classifies it and, for a counted hit, finds
// col/row/bin by three shared-step restoring dividers. Uses peh_pkg.
module peh_front #(
   parameter int COLS = 32,
   parameter int ROWS = 32,
   parameter int BINS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  peh_pkg::req_type  req_data,
   input  peh_pkg::cfg_type  cfg,
   output logic              front_busy,
   output logic              push,
   output peh_pkg::entry_type push_data,
   input  logic              full
);
   import peh_pkg::*;

   localparam int MAXN  = (COLS > ROWS) ? ((COLS > BINS) ? COLS : BINS)
                                        : ((ROWS > BINS) ? ROWS : BINS);
   localparam int STEPS = (MAXN > 1) ? $clog2(MAXN) : 1;
   localparam int SCW   = $clog2(STEPS + 1);

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_CHECK = 4'b0010,
      F_DIV   = 4'b0100,
      F_PUSH  = 4'b1000
   } fstate_type;

   fstate_type       state_ff, state_in;
   req_type          item_ff, item_in;
   entry_type        entry_ff, entry_in;
   logic [SCW-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0] remx_ff, remx_in, remz_ff, remz_in, reme_ff, reme_in;
   logic [DIV_W-1:0] dvx_ff, dvx_in, dvz_ff, dvz_in, dve_ff, dve_in;
   logic [STEPS-1:0] qx_ff, qx_in, qz_ff, qz_in, qe_ff, qe_in;

   logic signed [24:0] offx, offz;
   logic [DIV_W-1:0]   limx, limz, lime, nume;
   logic               grid_bad, range_bad, collim_bad, sel_ok;

   always_comb begin
      offx = {item_ff.pos_x[23], item_ff.pos_x} - {cfg.x_origin[23], cfg.x_origin};
      offz = {item_ff.pos_z[23], item_ff.pos_z} - {cfg.z_origin[23], cfg.z_origin};
      limx = DIV_W'(cfg.pitch_x) * DIV_W'(COLS);
      limz = DIV_W'(cfg.pitch_z) * DIV_W'(ROWS);
      lime = DIV_W'(cfg.energy_span) * DIV_W'(BINS);
      nume = DIV_W'(item_ff.energy - cfg.energy_min) * DIV_W'(BINS);
      grid_bad = (cfg.pitch_x == '0) || offx[24] || (DIV_W'(offx[23:0]) >= limx) ||
                 (cfg.pitch_z == '0) || offz[24] || (DIV_W'(offz[23:0]) >= limz);
      range_bad = (cfg.energy_span == '0) || (item_ff.energy < cfg.energy_min) ||
                  (nume >= lime);
      collim_bad = (cfg.collimation_mode == MODE_PARALLEL) &&
                   (item_ff.dir_y < cfg.cos_tolerance);
      sel_ok = (int'(item_ff.sel_col) < COLS) && (int'(item_ff.sel_row) < ROWS) &&
               (int'(item_ff.sel_bin) < BINS);
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      entry_in = entry_ff;
      cnt_in   = cnt_ff;
      remx_in  = remx_ff;
      remz_in  = remz_ff;
      reme_in  = reme_ff;
      dvx_in   = dvx_ff;
      dvz_in   = dvz_ff;
      dve_in   = dve_ff;
      qx_in    = qx_ff;
      qz_in    = qz_ff;
      qe_in    = qe_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               item_in  = req_data;
               state_in = F_CHECK;
            end
         end
         F_CHECK: begin
            entry_in.sel_ok = sel_ok;
            entry_in.col    = '0;
            entry_in.row    = '0;
            entry_in.bin    = '0;
            remx_in = DIV_W'(offx[23:0]);
            remz_in = DIV_W'(offz[23:0]);
            reme_in = nume;
            dvx_in  = DIV_W'(cfg.pitch_x) << (STEPS - 1);
            dvz_in  = DIV_W'(cfg.pitch_z) << (STEPS - 1);
            dve_in  = DIV_W'(cfg.energy_span) << (STEPS - 1);
            qx_in   = '0;
            qz_in   = '0;
            qe_in   = '0;
            cnt_in  = SCW'(STEPS);
            state_in = F_PUSH;
            if (item_ff.func != FN_HIT) begin
               entry_in.op     = (item_ff.func == FN_CLEAR) ? OP_CLEAR : OP_READ;
               entry_in.status = ST_READOUT;
               entry_in.col    = IDX_W'(item_ff.sel_col);
               entry_in.row    = IDX_W'(item_ff.sel_row);
               entry_in.bin    = IDX_W'(item_ff.sel_bin);
            end else begin
               entry_in.op = OP_REJECT;
               priority if (item_ff.energy == '0) entry_in.status = ST_ZERO;
               else if (collim_bad) entry_in.status = ST_COLLIM;
               else if (grid_bad)   entry_in.status = ST_GRID;
               else if (range_bad)  entry_in.status = ST_RANGE;
               else begin
                  entry_in.op     = OP_HIT;
                  entry_in.status = ST_COUNTED;
                  state_in        = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (remx_ff >= dvx_ff) remx_in = remx_ff - dvx_ff;
            if (remz_ff >= dvz_ff) remz_in = remz_ff - dvz_ff;
            if (reme_ff >= dve_ff) reme_in = reme_ff - dve_ff;
            qx_in  = {qx_ff[STEPS-2:0], remx_ff >= dvx_ff};
            qz_in  = {qz_ff[STEPS-2:0], remz_ff >= dvz_ff};
            qe_in  = {qe_ff[STEPS-2:0], reme_ff >= dve_ff};
            dvx_in = dvx_ff >> 1;
            dvz_in = dvz_ff >> 1;
            dve_in = dve_ff >> 1;
            cnt_in = cnt_ff - SCW'(1);
            if (cnt_ff == SCW'(1)) begin
               entry_in.col = IDX_W'(qx_in);
               entry_in.row = IDX_W'(qz_in);
               entry_in.bin = IDX_W'(qe_in);
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff  <= item_in;
      entry_ff <= entry_in;
      cnt_ff   <= cnt_in;
      remx_ff  <= remx_in;
      remz_ff  <= remz_in;
      reme_ff  <= reme_in;
      dvx_ff   <= dvx_in;
      dvz_ff   <= dvz_in;
      dve_ff   <= dve_in;
      qx_ff    <= qx_in;
      qz_ff    <= qz_in;
      qe_ff    <= qe_in;
   end

   assign front_busy = (state_ff != F_IDLE);
   assign push       = (state_ff == F_PUSH) && !full;
   assign push_data  = entry_ff;

endmodule

/* rtl/peh_queue.sv */
// Two-entry queue of classified words between front and back end.
// Uses peh_pkg.
module peh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  peh_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output peh_pkg::entry_type pop_data,
   output logic               empty
);
   import peh_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      wr_in   = push ? ~wr_ff : wr_ff;
      rd_in   = pop ? ~rd_ff : rd_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) slot_ff[wr_ff] <= push_data;
   end

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = slot_ff[rd_ff];

endmodule

/* rtl/peh_back.sv */
// Back end: counter store with read-modify-write and a clearing sweep
// after reset; drives the result word. Uses peh_pkg.
module peh_back #(
   parameter int COLS = 32,
   parameter int ROWS = 32,
   parameter int BINS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  peh_pkg::entry_type pop_data,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_strobe,
   output peh_pkg::rsp_type   rsp_data
);
   import peh_pkg::*;

   localparam int DEPTH = COLS * ROWS * BINS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_READ = 3'b010,
      B_WRITE = 3'b100
   } bstate_type;

   logic [31:0]   mem [DEPTH];
   bstate_type    state_ff, state_in;
   entry_type     entry_ff, entry_in;
   logic [AW-1:0] addr_ff, addr_in, clr_ff, clr_in;
   logic          clearing_ff, clearing_in;
   logic [31:0]   rdata_ff, wdata;
   logic          we;
   logic          strobe_ff;
   rsp_type       rsp_ff, rsp_in;

   always_comb begin
      state_in    = state_ff;
      entry_in    = entry_ff;
      addr_in     = addr_ff;
      clr_in      = clr_ff + AW'(1);
      clearing_in = clearing_ff && (clr_ff != AW'(DEPTH - 1));
      pop         = 1'b0;
      we          = 1'b0;
      wdata       = '0;
      rsp_in      = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty && !clearing_ff) begin
               pop      = 1'b1;
               entry_in = pop_data;
               addr_in  = AW'((int'(pop_data.col) * ROWS + int'(pop_data.row)) * BINS
                              + int'(pop_data.bin));
               state_in = B_READ;
            end
         end
         B_READ: state_in = B_WRITE;
         B_WRITE: begin
            state_in      = B_IDLE;
            rsp_in.status = entry_ff.status;
            unique case (entry_ff.op)
               OP_HIT: begin
                  wdata = (rdata_ff == '1) ? rdata_ff : rdata_ff + 32'd1;
                  we    = 1'b1;
                  rsp_in.count = wdata;
               end
               OP_READ, OP_CLEAR: begin
                  we = entry_ff.sel_ok && (entry_ff.op == OP_CLEAR);
                  rsp_in.count = entry_ff.sel_ok ? rdata_ff : '0;
               end
               default: rsp_in.count = '0;
            endcase
            rsp_in.col = entry_ff.col[4:0];
            rsp_in.row = entry_ff.row[4:0];
            rsp_in.bin = entry_ff.bin[5:0];
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
         strobe_ff   <= (state_ff == B_WRITE);
      end
      entry_ff <= entry_in;
      addr_ff  <= addr_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr_ff];
      if (clearing_ff) mem[clr_ff] <= '0;
      else if (we) mem[addr_ff] <= wdata;
   end

   assign clearing   = clearing_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* rtl/peh_checker.sv */
// Port-level checks for the hit histogram, bound to the top level.
// Uses peh_pkg.
module peh_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input peh_pkg::rsp_type rsp_data,
   input logic             pready
);
   import peh_pkg::*;

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back result strobes");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy low after accept");

   a_sweep_busy: assert property (@(posedge clock)
      reset |=> busy) else $error("busy low during clearing sweep");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == ST_ZERO || rsp_data.status == ST_COLLIM ||
                     rsp_data.status == ST_GRID || rsp_data.status == ST_RANGE)
      |-> rsp_data.count == '0 && rsp_data.col == '0 && rsp_data.row == '0 &&
          rsp_data.bin == '0) else $error("reject result carries data");

   a_pready: assert property (@(posedge clock) pready) else $error("pready low");

endmodule

bind pixel_energy_hit_histogram peh_checker u_peh_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .pready(pready)
);
